// ===== rtl/core/ajb_pkg.sv =====
package ajb_pkg;

  localparam int DepthLog2 = 10;
  localparam int Depth     = 1 << DepthLog2;
  localparam int ByteW     = 8;
  localparam int HalfW     = 6;
  localparam int SampleW   = 2 * HalfW;
  localparam int FillW     = 10;
  localparam int CmpW      = (DepthLog2 > FillW) ? DepthLog2 : FillW;
  localparam int OutDataW  = 32;

  localparam int MarkBit   = 7;
  localparam int LowBit    = 6;

  localparam logic [FillW-1:0] ThrReset = FillW'(768);
  localparam logic [FillW-1:0] FillMax  = {FillW{1'b1}};

  typedef logic [DepthLog2-1:0] ptr_t;

  typedef struct packed {
    logic               push;
    logic               pop;
    logic [SampleW-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [SampleW-1:0] head;
    ptr_t               count;
    ptr_t               count_next;
  } ring_stat_t;

endpackage

// ===== rtl/core/ajb_ring.sv =====
module ajb_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ajb_pkg::ring_req_t req_i,
  output ajb_pkg::ring_stat_t stat_o
);

  logic [ajb_pkg::SampleW-1:0] mem [ajb_pkg::Depth];
  ajb_pkg::ptr_t rd_q, rd_d, wr_q, wr_d;
  logic [ajb_pkg::SampleW-1:0] head_q;

  always_comb begin
    rd_d = req_i.pop  ? rd_q + ajb_pkg::ptr_t'(1) : rd_q;
    wr_d = req_i.push ? wr_q + ajb_pkg::ptr_t'(1) : wr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem[wr_q] <= req_i.wdata;
    end
  end

  // head of the queue, with write forwarding when the new entry becomes the head
  always_ff @(posedge clk_i) begin
    if (req_i.push && (wr_q == rd_d)) begin
      head_q <= req_i.wdata;
    end else begin
      head_q <= mem[rd_d];
    end
  end

  always_comb begin
    stat_o.full       = (wr_q + ajb_pkg::ptr_t'(1)) == rd_q;
    stat_o.empty      = wr_q == rd_q;
    stat_o.head       = head_q;
    stat_o.count      = wr_q - rd_q;
    stat_o.count_next = wr_d - rd_d;
  end

endmodule

// ===== rtl/core/audio_jitter_buffer_player.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: op, tdata: rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: dac_write .. fill_level
// cfg       in   cfg_we_i                     cfg_wdata_i: start_threshold
//
// one item per cycle sustained while the output is not stalled, and
// the input register and result register form a two-stage pipeline, so a new
// item is taken while a result waits; a stalled output holds both stages
// the sample ring is a 1024 x 12 memory with one registered read of the head
// reset clears pointers, mode, latched half and threshold (768); no clearing pass
module audio_jitter_buffer_player (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic                         s_axis_tuser,  // op
  input  logic [ajb_pkg::ByteW-1:0]    s_axis_tdata,  // rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // dac_write, dac_value[12], request_sample, connected, overflow, fill_level[10]
  output logic [ajb_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_we_i,
  input  logic [ajb_pkg::FillW-1:0]    cfg_wdata_i
);

  logic                       in_v_q;
  logic                       op_q;
  logic [ajb_pkg::ByteW-1:0]  byte_q;
  logic                       out_v_q;
  logic [ajb_pkg::OutDataW-1:0] out_q, out_d;
  logic [ajb_pkg::FillW-1:0]  thr_q;
  logic [ajb_pkg::HalfW-1:0]  half_q, half_d;
  logic                       mode_q, mode_d;
  logic                       adv;
  logic                       complete, ovf, tick;
  logic [ajb_pkg::CmpW-1:0]   cnt_ext, cnt_nxt_ext;
  logic [ajb_pkg::FillW-1:0]  fill;
  ajb_pkg::ring_req_t         req;
  ajb_pkg::ring_stat_t        stat;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q   <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  ajb_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .stat_o (stat)
  );

  always_comb begin
    tick        = op_q;
    complete    = !op_q && byte_q[ajb_pkg::MarkBit] && byte_q[ajb_pkg::LowBit];
    ovf         = complete && stat.full;
    cnt_ext     = ajb_pkg::CmpW'(stat.count);
    cnt_nxt_ext = ajb_pkg::CmpW'(stat.count_next);
    half_d      = half_q;
    mode_d      = mode_q;
    req.push    = adv && complete && !stat.full;
    req.pop     = 1'b0;
    req.wdata   = {half_q, byte_q[ajb_pkg::HalfW-1:0]};
    if (!op_q && byte_q[ajb_pkg::MarkBit] && !byte_q[ajb_pkg::LowBit]) begin
      half_d = byte_q[ajb_pkg::HalfW-1:0];
    end
    if (tick) begin
      if (!mode_q) begin
        if (cnt_ext > ajb_pkg::CmpW'(thr_q)) begin
          mode_d = 1'b1;
        end
      end else if (stat.empty) begin
        mode_d = 1'b0;
      end else begin
        req.pop = adv;
      end
    end
    if (cnt_nxt_ext > ajb_pkg::CmpW'(ajb_pkg::FillMax)) begin
      fill = ajb_pkg::FillMax;
    end else begin
      fill = cnt_nxt_ext[ajb_pkg::FillW-1:0];
    end
    out_d = ajb_pkg::OutDataW'({fill, ovf, mode_d, tick,
                                req.pop ? stat.head : '0, req.pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      half_q  <= '0;
      mode_q  <= 1'b0;
      thr_q   <= ajb_pkg::ThrReset;
    end else begin
      if (adv) begin
        out_v_q <= 1'b1;
        half_q  <= half_d;
        mode_q  <= mode_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  a_ring_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("ring reports full and empty at once");

  a_pop_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[14] && m_axis_tdata[13]))
    else $error("sample played while not connected or not on a tick");

  a_ovf_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[15]) |-> !m_axis_tdata[13])
    else $error("overflow flagged on a tick");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.push |=> !stat.empty)
    else $error("ring empty right after a push");

endmodule
